// ----- rtl/twa_pkg.sv -----
// types, constants and helpers shared by the t-wave alternans detector
// depends on nothing; imported by every module of the block

package twa_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int POSITION_WIDTH = 24;
   localparam int COUNT_WIDTH    = 24;
   localparam int RATIO_WIDTH    = 10;
   localparam int MAX_REPORTS    = 4;
   localparam int PRODUCT_WIDTH  = COUNT_WIDTH + RATIO_WIDTH;

   localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(20);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;

   typedef enum logic {
      KIND_BEAT    = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   // one input beat
   typedef struct packed {
      logic [POSITION_WIDTH-1:0]      beat_position;
      logic signed [SAMPLE_WIDTH-1:0] t_end_amplitude;
      logic                           last_beat;
   } beat_type;

   // one result
   typedef struct packed {
      result_kind_type           result_kind;
      logic [COUNT_WIDTH-1:0]    beat_number;
      logic [POSITION_WIDTH-1:0] beat_sample_position;
      logic [COUNT_WIDTH-1:0]    flagged_count;
      logic [COUNT_WIDTH-1:0]    window_count;
      logic                      alternans_present;
      logic                      last_result;
   } result_type;

   // all results of one beat; slot 0 is the beat leaving the window,
   // slots 1..3 the held beats flushed at end of record, oldest first
   typedef struct packed {
      logic [MAX_REPORTS-1:0]                     rep_mask;
      logic [MAX_REPORTS-1:0][COUNT_WIDTH-1:0]    rep_num;
      logic [MAX_REPORTS-1:0][POSITION_WIDTH-1:0] rep_pos;
      logic                                       summary;
      logic [COUNT_WIDTH-1:0]                     flagged;
      logic [COUNT_WIDTH-1:0]                     windows;
      logic                                       alt;
   } job_type;

   // saturating increment of a counter
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
      sat_inc = (x == COUNT_MAX) ? x : x + COUNT_WIDTH'(1);
   endfunction

   // ordinal of a beat 'back' places older than the newest one, floored at zero
   function automatic logic [COUNT_WIDTH-1:0] ord_back(input logic [COUNT_WIDTH-1:0] bc,
                                                       input logic [2:0] back);
      ord_back = (bc >= COUNT_WIDTH'(back)) ? bc - COUNT_WIDTH'(back) : '0;
   endfunction

   // magnitude of the difference of two samples
   function automatic logic [SAMPLE_WIDTH-1:0] abs_diff(input logic signed [SAMPLE_WIDTH-1:0] a,
                                                        input logic signed [SAMPLE_WIDTH-1:0] b);
      logic signed [SAMPLE_WIDTH:0] d;
      d = (SAMPLE_WIDTH+1)'(a) - (SAMPLE_WIDTH+1)'(b);
      abs_diff = d[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-d) : d[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

// ----- rtl/twa_front.sv -----
// front end: accepts beats, keeps the three-beat window and record counters,
// builds one job per beat with results and works out the alternans verdict; uses twa_pkg

module twa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  twa_pkg::beat_type              req_data,
   input  logic [twa_pkg::RATIO_WIDTH-1:0] ratio,
   output logic                           job_valid,
   input  logic                           job_ready,
   output twa_pkg::job_type               job
);
   import twa_pkg::*;

   // held window, oldest first
   logic signed [SAMPLE_WIDTH-1:0] amp_ff [3];
   logic signed [SAMPLE_WIDTH-1:0] amp_in [3];
   logic [POSITION_WIDTH-1:0]      pos_ff [3];
   logic [POSITION_WIDTH-1:0]      pos_in [3];
   logic [2:0]                     flag_ff, flag_in;
   logic [1:0]                     held_ff, held_in;
   logic [COUNT_WIDTH-1:0]         bc_ff, bc_in;
   logic [COUNT_WIDTH-1:0]         win_ff, win_in;
   logic [COUNT_WIDTH-1:0]         flg_ff, flg_in;

   // pipeline registers
   logic                           a_valid_ff;
   job_type                        a_job_ff, a_job_in;
   logic                           b_valid_ff;
   job_type                        b_job_ff;
   logic [PRODUCT_WIDTH-1:0]       b_prod_ff;

   logic                           ready_a, ready_b, accept;
   logic                           full, pass, evict, nonempty;
   logic [SAMPLE_WIDTH-1:0]        d12, d13, d24, d34;
   logic [2:0]                     flag_upd;
   logic [COUNT_WIDTH-1:0]         bc_new, win_new, flg_final;
   logic [2:0]                     n_reports;
   logic [COUNT_WIDTH:0]           flg_sum;

   // stall chain
   assign ready_b   = !b_valid_ff || job_ready;
   assign ready_a   = !a_valid_ff || ready_b;
   assign req_ready = ready_a;
   assign accept    = req_valid && req_ready;

   // window test
   assign full = (held_ff == 2'd3);
   assign d13  = abs_diff(amp_ff[0], amp_ff[2]);
   assign d12  = abs_diff(amp_ff[0], amp_ff[1]);
   assign d24  = abs_diff(amp_ff[1], req_data.t_end_amplitude);
   assign d34  = abs_diff(amp_ff[2], req_data.t_end_amplitude);
   assign pass = full && (d13 < d12) && (d24 < d34) && (d24 < d12) && (d13 < d34);
   assign flag_upd = flag_ff | {3{pass}};
   assign evict    = full && flag_upd[0];
   assign bc_new   = sat_inc(bc_ff);
   assign win_new  = full ? sat_inc(win_ff) : win_ff;

   // next window contents
   always_comb begin
      if (full) begin
         amp_in[0] = amp_ff[1];
         amp_in[1] = amp_ff[2];
         amp_in[2] = req_data.t_end_amplitude;
         pos_in[0] = pos_ff[1];
         pos_in[1] = pos_ff[2];
         pos_in[2] = req_data.beat_position;
         flag_in   = {pass, flag_upd[2:1]};
         held_in   = 2'd3;
      end else begin
         for (int j = 0; j < 3; j++) begin
            amp_in[j]  = (2'(j) == held_ff) ? req_data.t_end_amplitude : amp_ff[j];
            pos_in[j]  = (2'(j) == held_ff) ? req_data.beat_position : pos_ff[j];
            flag_in[j] = (2'(j) == held_ff) ? 1'b0 : flag_ff[j];
         end
         held_in = held_ff + 2'd1;
      end
   end

   // job for this beat
   always_comb begin
      a_job_in            = '0;
      a_job_in.rep_mask[0] = evict;
      a_job_in.rep_num[0]  = ord_back(bc_new, 3'd4);
      a_job_in.rep_pos[0]  = pos_ff[0];
      for (int j = 0; j < 3; j++) begin
         a_job_in.rep_mask[j+1] = req_data.last_beat && flag_in[j] && (2'(j) < held_in);
         a_job_in.rep_num[j+1]  = ord_back(bc_new, {1'b0, held_in} - 3'(j));
         a_job_in.rep_pos[j+1]  = pos_in[j];
      end
      n_reports = '0;
      for (int j = 0; j < MAX_REPORTS; j++) begin
         n_reports = n_reports + 3'(a_job_in.rep_mask[j]);
      end
      flg_sum   = (COUNT_WIDTH+1)'(flg_ff) + (COUNT_WIDTH+1)'(n_reports);
      flg_final = flg_sum[COUNT_WIDTH] ? COUNT_MAX : flg_sum[COUNT_WIDTH-1:0];
      a_job_in.summary = req_data.last_beat;
      a_job_in.flagged = flg_final;
      a_job_in.windows = win_new;
      nonempty         = evict || req_data.last_beat;
   end

   // record state after this beat
   always_comb begin
      bc_in  = bc_new;
      win_in = win_new;
      flg_in = flg_final;
      if (req_data.last_beat) begin
         bc_in  = '0;
         win_in = '0;
         flg_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            amp_ff[j] <= '0;
            pos_ff[j] <= '0;
         end
         flag_ff <= '0;
         held_ff <= '0;
         bc_ff   <= '0;
         win_ff  <= '0;
         flg_ff  <= '0;
      end else if (accept) begin
         for (int j = 0; j < 3; j++) begin
            amp_ff[j] <= req_data.last_beat ? '0 : amp_in[j];
            pos_ff[j] <= req_data.last_beat ? '0 : pos_in[j];
         end
         flag_ff <= req_data.last_beat ? '0 : flag_in;
         held_ff <= req_data.last_beat ? '0 : held_in;
         bc_ff   <= bc_in;
         win_ff  <= win_in;
         flg_ff  <= flg_in;
      end
   end

   // stage a: job register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ready_a) begin
         a_valid_ff <= accept && nonempty;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_job_ff <= a_job_in;
      end
   end

   // stage b: flagged count times ratio
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (ready_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_job_ff  <= a_job_ff;
         b_prod_ff <= PRODUCT_WIDTH'(a_job_ff.flagged) * PRODUCT_WIDTH'(ratio);
      end
   end

   // verdict and hand-off to the queue
   always_comb begin
      job     = b_job_ff;
      job.alt = (b_job_ff.windows != '0) && (b_prod_ff >= PRODUCT_WIDTH'(b_job_ff.windows));
   end

   assign job_valid = b_valid_ff;

endmodule

// ----- rtl/twa_queue.sv -----
// short job queue between front and back end
// depends on twa_pkg for the job type

module twa_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  twa_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output twa_pkg::job_type pop_data
);
   import twa_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   job_type                mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   push, pop;

   assign push_ready = (cnt_ff != CNT_WIDTH'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/twa_back.sv -----
// back end: walks jobs, a result per free cycle, into the output register
// depends on twa_pkg for job and result types

module twa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  twa_pkg::job_type    job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output twa_pkg::result_type rsp_data
);
   import twa_pkg::*;

   logic                   cur_valid_ff, cur_valid_in;
   job_type                cur_ff, cur_in;
   logic                   out_valid_ff;
   result_type             out_ff, out_in;
   logic                   slot_free, step, done, found;
   logic [1:0]             idx;
   logic [MAX_REPORTS-1:0] mask_rest;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign step      = cur_valid_ff && slot_free;
   assign job_ready = !cur_valid_ff || (step && done);

   // oldest pending report
   always_comb begin
      idx   = '0;
      found = 1'b0;
      for (int j = MAX_REPORTS - 1; j >= 0; j--) begin
         if (cur_ff.rep_mask[j]) begin
            idx   = 2'(j);
            found = 1'b1;
         end
      end
      mask_rest      = cur_ff.rep_mask;
      mask_rest[idx] = 1'b0;
   end

   // result for this cycle
   always_comb begin
      out_in = '0;
      if (found) begin
         out_in.result_kind          = KIND_BEAT;
         out_in.beat_number          = cur_ff.rep_num[idx];
         out_in.beat_sample_position = cur_ff.rep_pos[idx];
         out_in.last_result          = (mask_rest == '0) && !cur_ff.summary;
      end else begin
         out_in.result_kind       = KIND_SUMMARY;
         out_in.flagged_count     = cur_ff.flagged;
         out_in.window_count      = cur_ff.windows;
         out_in.alternans_present = cur_ff.alt;
         out_in.last_result       = 1'b1;
      end
      done = out_in.last_result;
   end

   // current job
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (step) begin
         cur_in.rep_mask = mask_rest;
         if (done) begin
            cur_valid_in = 1'b0;
         end
      end
      if (job_valid && job_ready) begin
         cur_valid_in = 1'b1;
         cur_in       = job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         if (slot_free) begin
            out_valid_ff <= step;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (slot_free) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/t_wave_alternans_detector.sv -----
// top level of the t-wave alternans detector: ratio register, front, queue, back
// depends on twa_pkg, twa_front, twa_queue and twa_back
//
//   channel  ports                        carries
//   req      req_valid/req_ready/req_data  one beat (position, amplitude, last flag)
//   rsp      rsp_valid/rsp_ready/rsp_data  beat reports and record summary
//   csr      csr_valid/csr_ready/csr_data  ratio_inverse write, always ready
//
// one beat accepted per cycle while req_ready is high; its job is registered in stages a and b
// a beat gives up to five results, one per cycle from the back end's output register while
// rsp_ready is high, so the result side sets the rate if several beats in a row give results
// synchronous active-high reset clears window, counters and pipeline; ratio returns to 20
// a stalled result channel fills the job queue and then holds req_ready low

module t_wave_alternans_detector #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  twa_pkg::beat_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output twa_pkg::result_type             rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [twa_pkg::RATIO_WIDTH-1:0] csr_data
);
   import twa_pkg::*;

   logic [RATIO_WIDTH-1:0] ratio_ff;
   logic                   f_valid, f_ready, q_valid, q_ready;
   job_type                f_job, q_job;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else if (csr_valid && csr_ready) begin
         ratio_ff <= csr_data;
      end
   end

   twa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .ratio     (ratio_ff),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   twa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_job)
   );

   twa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a summary always closes the results of its beat
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_SUMMARY |-> rsp_data.last_result)
      else $error("summary not marked as last result");

   // alternans needs at least one tested window
   a_alt_windows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alternans_present |->
         rsp_data.result_kind == KIND_SUMMARY && rsp_data.window_count != '0)
      else $error("alternans reported without tested windows");

   // a beat report carries no record figures
   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_BEAT |->
         rsp_data.flagged_count == '0 && rsp_data.window_count == '0)
      else $error("beat report carries summary fields");

   // nothing leaves the block in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

// ----- sim/tb_t_wave_alternans_detector.sv -----
// testbench for the t-wave alternans detector: directed beat table, then random records
// under several ratio settings, every result checked against a typed summary or an in-bench window predictor
// depends on twa_pkg and t_wave_alternans_detector
`timescale 1ns / 1ps

module tb_t_wave_alternans_detector;
   import twa_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEMS_PHASE  = 64;
   localparam int DRAIN_CYCLES = 12;

   // stimulus table row; typed rows carry their expected summary directly
   typedef struct {
      beat_type   beat;
      bit         typed;
      result_type typed_res;
   } beat_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   beat_type               req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   result_type             rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [RATIO_WIDTH-1:0] csr_data  = '0;

   // window predictor state
   logic signed [SAMPLE_WIDTH-1:0] win_amp[3];
   logic [POSITION_WIDTH-1:0]      win_pos[3];
   bit                             win_flag[3];
   int unsigned                    held_n;
   logic [COUNT_WIDTH-1:0]         beat_cnt, win_cnt, flag_cnt;
   logic [RATIO_WIDTH-1:0]         ratio_set;

   result_type   beat_results[5];
   int           beat_result_count;
   result_type   pending_results[$];
   beat_row_type beat_script[$];

   int error_count = 0;
   int cycle_count = 0;
   bit steady      = 1'b0;
   int hold_off    = 0;

   t_wave_alternans_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("t_wave_alternans_detector: mismatch");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("error at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // mostly short gaps, a few long ones, none in steady stretches
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] x);
      return (x == '1) ? x : x + COUNT_WIDTH'(1);
   endfunction

   function automatic int amp_gap(input logic signed [SAMPLE_WIDTH-1:0] a,
                                  input logic signed [SAMPLE_WIDTH-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic result_type make_summary(input logic [COUNT_WIDTH-1:0] fl,
                                               input logic [COUNT_WIDTH-1:0] wn,
                                               input logic alt);
      result_type r;
      r = '0;
      r.result_kind       = KIND_SUMMARY;
      r.flagged_count     = fl;
      r.window_count      = wn;
      r.alternans_present = alt;
      r.last_result       = 1'b1;
      return r;
   endfunction

   task automatic clear_record_model();
      for (int i = 0; i < 3; i++) begin
         win_amp[i]  = '0;
         win_pos[i]  = '0;
         win_flag[i] = 1'b0;
      end
      held_n   = 0;
      beat_cnt = '0;
      win_cnt  = '0;
      flag_cnt = '0;
   endtask

   // flagged beat report for a beat 'back' places older than the newest one
   task automatic add_report(input int unsigned back, input logic [POSITION_WIDTH-1:0] pos);
      result_type r;
      r = '0;
      flag_cnt = count_up(flag_cnt);
      r.result_kind          = KIND_BEAT;
      r.beat_number          = (beat_cnt >= COUNT_WIDTH'(back)) ?
                               beat_cnt - COUNT_WIDTH'(back) : '0;
      r.beat_sample_position = pos;
      beat_results[beat_result_count] = r;
      beat_result_count++;
   endtask

   // advance the window by one beat and collect the results it causes
   task automatic predict_beat_results(input beat_type b);
      int d13, d12, d24, d34;
      bit pass;
      logic [63:0] product;
      begin
         beat_result_count = 0;
         pass = 1'b0;
         beat_cnt = count_up(beat_cnt);
         if (held_n == 3) begin
            d13 = amp_gap(win_amp[0], win_amp[2]);
            d12 = amp_gap(win_amp[0], win_amp[1]);
            d24 = amp_gap(win_amp[1], b.t_end_amplitude);
            d34 = amp_gap(win_amp[2], b.t_end_amplitude);
            win_cnt = count_up(win_cnt);
            if (d13 < d12 && d24 < d34 && d24 < d12 && d13 < d34) begin
               win_flag[0] = 1'b1;
               win_flag[1] = 1'b1;
               win_flag[2] = 1'b1;
               pass = 1'b1;
            end
            // oldest beat leaves the window
            if (win_flag[0])
               add_report(4, win_pos[0]);
            for (int i = 0; i < 2; i++) begin
               win_amp[i]  = win_amp[i+1];
               win_pos[i]  = win_pos[i+1];
               win_flag[i] = win_flag[i+1];
            end
            win_amp[2]  = b.t_end_amplitude;
            win_pos[2]  = b.beat_position;
            win_flag[2] = pass;
         end else begin
            win_amp[held_n]  = b.t_end_amplitude;
            win_pos[held_n]  = b.beat_position;
            win_flag[held_n] = 1'b0;
            held_n++;
         end
         // end of record: flush held flagged beats, then the summary
         if (b.last_beat) begin
            for (int unsigned i = 0; i < held_n; i++)
               if (win_flag[i])
                  add_report(held_n - i, win_pos[i]);
            product = 64'(flag_cnt) * 64'(ratio_set);
            beat_results[beat_result_count] =
               make_summary(flag_cnt, win_cnt, (win_cnt != '0) && (product >= 64'(win_cnt)));
            beat_result_count++;
            clear_record_model();
         end
         for (int i = 0; i < beat_result_count; i++)
            beat_results[i].last_result = (i == beat_result_count - 1);
      end
   endtask

   // offer one beat, hold it until the transfer, then queue what it should produce
   task automatic issue_beat(input beat_type b, input bit typed, input result_type typed_res);
      int gap;
      begin
         gap = pick_gap();
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         @(negedge clock);
         req_valid = 1'b1;
         req_data  = b;
         do @(posedge clock); while (!req_ready);
         predict_beat_results(b);
         if (typed) begin
            if (b.last_beat)
               pending_results.push_back(typed_res);
         end else begin
            for (int i = 0; i < beat_result_count; i++)
               pending_results.push_back(beat_results[i]);
         end
      end
   endtask

   // drop valid, wait for every expected result and let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ratio(input logic [RATIO_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      ratio_set = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void add_row(input logic [POSITION_WIDTH-1:0] pos, input int amp,
                                   input bit last, input bit typed,
                                   input logic [COUNT_WIDTH-1:0] fl,
                                   input logic [COUNT_WIDTH-1:0] wn, input bit alt);
      beat_row_type row;
      row.beat.beat_position   = pos;
      row.beat.t_end_amplitude = SAMPLE_WIDTH'(amp);
      row.beat.last_beat       = last;
      row.typed                = typed;
      row.typed_res            = make_summary(fl, wn, alt);
      beat_script.push_back(row);
   endfunction

   // result side: random stalls
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready = 1'b0;
         hold_off--;
      end else begin
         rsp_ready = 1'b1;
         hold_off = pick_gap();
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", 32'(rsp_data.result_kind), 32'(want.result_kind));
            check_field("beat_number", 32'(rsp_data.beat_number), 32'(want.beat_number));
            check_field("beat_sample_position", 32'(rsp_data.beat_sample_position),
                        32'(want.beat_sample_position));
            check_field("flagged_count", 32'(rsp_data.flagged_count), 32'(want.flagged_count));
            check_field("window_count", 32'(rsp_data.window_count), 32'(want.window_count));
            check_field("alternans_present", 32'(rsp_data.alternans_present),
                        32'(want.alternans_present));
            check_field("last_result", 32'(rsp_data.last_result), 32'(want.last_result));
         end
      end
   end

   initial begin
      logic [RATIO_WIDTH-1:0] ratio_plan[6];
      beat_type   b;
      result_type none;
      int sent, len, style, base, swing, amp, k;
      logic [POSITION_WIDTH-1:0] pos;

      none = '0;
      ratio_set = RATIO_RESET;
      clear_record_model();

      // reset
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-beat record: empty summary
      add_row(24'h000000, 0, 1, 1, 0, 0, 0);
      // three beats, extreme positions and amplitudes: no window tested
      add_row(24'hFFFFFF, 32767, 0, 1, 0, 0, 0);
      add_row(24'h000001, -32768, 0, 1, 0, 0, 0);
      add_row(24'h000002, -1, 1, 1, 0, 0, 0);
      // flat record: one window tested, none passes
      add_row(24'd10, 5, 0, 1, 0, 0, 0);
      add_row(24'd20, 5, 0, 1, 0, 0, 0);
      add_row(24'd30, 5, 0, 1, 0, 0, 0);
      add_row(24'd40, 5, 1, 1, 0, 1, 0);
      // clean alternation: reports as beats leave, flush at the end
      add_row(24'd100, 100, 0, 0, 0, 0, 0);
      add_row(24'd350, -100, 0, 0, 0, 0, 0);
      add_row(24'd600, 100, 0, 0, 0, 0, 0);
      add_row(24'd850, -100, 0, 0, 0, 0, 0);
      add_row(24'd1100, 100, 0, 0, 0, 0, 0);
      add_row(24'd1350, -100, 1, 0, 0, 0, 0);
      // full-scale alternation ending on the fourth beat: five results from one beat
      add_row(24'h800000, -32768, 0, 0, 0, 0, 0);
      add_row(24'hFFFFFF, 32767, 0, 0, 0, 0, 0);
      add_row(24'h000001, -32768, 0, 0, 0, 0, 0);
      add_row(24'h7FFFFF, 32767, 1, 0, 0, 0, 0);
      // near miss: in each tested window one comparison ties
      add_row(24'd5000, 0, 0, 0, 0, 0, 0);
      add_row(24'd5250, 10, 0, 0, 0, 0, 0);
      add_row(24'd5500, 5, 0, 0, 0, 0, 0);
      add_row(24'd5750, 10, 0, 0, 0, 0, 0);
      add_row(24'd6000, 0, 1, 0, 0, 0, 0);

      foreach (beat_script[i])
         issue_beat(beat_script[i].beat, beat_script[i].typed, beat_script[i].typed_res);

      // random records under each ratio setting, zero and the top of the field included
      ratio_plan[0] = '0;
      ratio_plan[1] = RATIO_WIDTH'(1);
      ratio_plan[2] = RATIO_WIDTH'(1000);
      ratio_plan[3] = '1;
      ratio_plan[4] = RATIO_WIDTH'($urandom_range(2, 999));
      ratio_plan[5] = RATIO_RESET;

      foreach (ratio_plan[p]) begin
         settle();
         write_ratio(ratio_plan[p]);
         sent = 0;
         while (sent < ITEMS_PHASE) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
            style  = $urandom_range(0, 9);
            steady = ($urandom_range(0, 4) == 0);
            base   = int'($urandom_range(0, 16000)) - 8000;
            swing  = $urandom_range(1, 20000);
            pos    = POSITION_WIDTH'($urandom_range(0, 24'hFFFFFF));
            for (k = 0; k < len && sent < ITEMS_PHASE; k++) begin
               amp = base + ((k % 2) ? -swing : swing) + int'($urandom_range(0, 64)) - 32;
               if (style == 6 || style == 7 || (style == 9 && $urandom_range(0, 4) == 0))
                  amp = $urandom_range(0, 65535);
               else if (style == 8)
                  amp = base;
               pos = pos + POSITION_WIDTH'($urandom_range(200, 400));
               b.beat_position   = (style == 7) ? POSITION_WIDTH'($urandom_range(0, 24'hFFFFFF))
                                                : pos;
               b.t_end_amplitude = SAMPLE_WIDTH'(amp);
               b.last_beat       = (k == len - 1) || (sent == ITEMS_PHASE - 1);
               issue_beat(b, 1'b0, none);
               sent++;
            end
         end
      end

      steady = 1'b0;
      settle();
      if (error_count == 0)
         $display("t_wave_alternans_detector: match");
      else
         $display("t_wave_alternans_detector: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/twa_pkg.sv
rtl/twa_front.sv
rtl/twa_queue.sv
rtl/twa_back.sv
rtl/t_wave_alternans_detector.sv
sim/tb_t_wave_alternans_detector.sv
